>>> rtl/mm3_pkg.sv
// Shared types, constants and helper functions for the Murmur3 hash block.
package mm3_pkg;

   localparam logic [31:0] C1 = 32'hcc9e2d51;
   localparam logic [31:0] C2 = 32'h1b873593;
   localparam logic [31:0] MixAdd = 32'he6546b64;
   localparam logic [31:0] F1 = 32'h85ebca6b;
   localparam logic [31:0] F2 = 32'hc2b2ae35;
   localparam int unsigned R1 = 15;
   localparam int unsigned R2 = 13;

   localparam logic [31:0] SeedReset = 32'd42;

   localparam logic [2:0] FullCount = 3'd4;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
   localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [31:0] key;
      logic [2:0]  count;
      logic        full_block;
      logic        ends_key;
   } item_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
      rotl = (x << r) | (x >> (32 - r));
   endfunction

   function automatic logic [31:0] byte_mask(input logic [2:0] count);
      logic [31:0] m;
      case (count)
         3'd0: m = 32'h00000000;
         3'd1: m = 32'h000000ff;
         3'd2: m = 32'h0000ffff;
         3'd3: m = 32'h00ffffff;
         default: m = 32'hffffffff;
      endcase
      byte_mask = m;
   endfunction

endpackage

>>> rtl/mm3_front.sv
// Front end: accepts key words, classifies them and scrambles the key bytes.
module mm3_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [31:0]         req_key_word,
   input  logic [2:0]          req_byte_count,
   input  logic                req_last_word,
   output logic                push_valid,
   input  logic                push_ready,
   output mm3_pkg::item_type   push_item
);

   logic              a_valid_ff, a_valid_in;
   logic              b_valid_ff, b_valid_in;
   logic              c_valid_ff, c_valid_in;
   mm3_pkg::item_type a_item_ff, a_item_in;
   mm3_pkg::item_type b_item_ff, b_item_in;
   mm3_pkg::item_type c_item_ff, c_item_in;
   logic              a_adv, b_adv, c_adv;
   logic              a_load;
   logic [2:0]        count;

   assign c_adv = c_valid_ff && push_ready;
   assign b_adv = b_valid_ff && (!c_valid_ff || c_adv);
   assign a_adv = a_valid_ff && (!b_valid_ff || b_adv);
   assign req_ready = !a_valid_ff || a_adv;
   assign a_load = req_valid && req_ready;

   assign push_valid = c_valid_ff;
   assign push_item = c_item_ff;

   always_comb begin
      count = req_byte_count;
      if (req_byte_count inside {3'd5, 3'd6, 3'd7}) begin
         count = mm3_pkg::FullCount;
      end

      a_item_in = a_item_ff;
      a_valid_in = a_valid_ff;
      if (a_load) begin
         a_item_in.key = req_key_word & mm3_pkg::byte_mask(count);
         a_item_in.count = count;
         a_item_in.full_block = (count == mm3_pkg::FullCount);
         a_item_in.ends_key = (count != mm3_pkg::FullCount) || req_last_word;
         a_valid_in = 1'b1;
      end else if (a_adv) begin
         a_valid_in = 1'b0;
      end

      b_item_in = b_item_ff;
      b_valid_in = b_valid_ff;
      if (a_adv) begin
         b_item_in = a_item_ff;
         b_item_in.key = a_item_ff.key * mm3_pkg::C1;
         b_valid_in = 1'b1;
      end else if (b_adv) begin
         b_valid_in = 1'b0;
      end

      c_item_in = c_item_ff;
      c_valid_in = c_valid_ff;
      if (b_adv) begin
         c_item_in = b_item_ff;
         c_item_in.key = mm3_pkg::rotl(b_item_ff.key, mm3_pkg::R1) * mm3_pkg::C2;
         c_valid_in = 1'b1;
      end else if (c_adv) begin
         c_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
      a_item_ff <= a_item_in;
      b_item_ff <= b_item_in;
      c_item_ff <= c_item_in;
   end

endmodule

>>> rtl/mm3_queue.sv
// Small FIFO that decouples the front end from the hash back end.
module mm3_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  mm3_pkg::item_type   push_item,
   output logic                pop_valid,
   input  logic                pop_ready,
   output mm3_pkg::item_type   pop_item
);

   mm3_pkg::item_type                     entry_ff [mm3_pkg::QueueDepth];
   logic [mm3_pkg::QueuePtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [mm3_pkg::QueuePtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [mm3_pkg::QueueCntWidth-1:0]     cnt_ff, cnt_in;
   logic                                  do_push, do_pop;

   assign push_ready = (cnt_ff != mm3_pkg::QueueCntWidth'(mm3_pkg::QueueDepth));
   assign pop_valid = (cnt_ff != '0);
   assign pop_item = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/mm3_back.sv
// Back end: running hash update, length tracking, finalizer and result register.
module mm3_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         seed,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  mm3_pkg::item_type   pop_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [31:0]         rsp_hash_value
);

   localparam logic [1:0] StRun = 2'd0;
   localparam logic [1:0] StFin1 = 2'd1;
   localparam logic [1:0] StFin2 = 2'd2;
   localparam logic [1:0] StFin3 = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] len_ff, len_in;
   logic        start_ff, start_in;
   logic [31:0] fin_ff, fin_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_hash_ff, rsp_hash_in;
   logic [31:0] base_hash, base_len, len_new, mixed, blocked;
   logic        do_pop;

   assign pop_ready = (state_ff == StRun);
   assign do_pop = pop_valid && pop_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   always_comb begin
      base_hash = start_ff ? seed : hash_ff;
      base_len = start_ff ? 32'd0 : len_ff;
      len_new = base_len + {29'd0, pop_item.count};
      mixed = base_hash ^ pop_item.key;
      blocked = (mm3_pkg::rotl(mixed, mm3_pkg::R2) * 32'd5) + mm3_pkg::MixAdd;

      state_in = state_ff;
      hash_in = hash_ff;
      len_in = len_ff;
      start_in = start_ff;
      fin_in = fin_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hash_in = rsp_hash_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         StRun: begin
            if (do_pop) begin
               len_in = len_new;
               if (pop_item.ends_key) begin
                  fin_in = (pop_item.full_block ? blocked : mixed) ^ len_new;
                  start_in = 1'b1;
                  state_in = StFin1;
               end else begin
                  hash_in = blocked;
                  start_in = 1'b0;
               end
            end
         end
         StFin1: begin
            fin_in = (fin_ff ^ (fin_ff >> 16)) * mm3_pkg::F1;
            state_in = StFin2;
         end
         StFin2: begin
            fin_in = (fin_ff ^ (fin_ff >> 13)) * mm3_pkg::F2;
            state_in = StFin3;
         end
         StFin3: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_hash_in = fin_ff ^ (fin_ff >> 16);
               rsp_valid_in = 1'b1;
               state_in = StRun;
            end
         end
         default: begin
            state_in = StRun;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StRun;
         start_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         hash_ff <= mm3_pkg::SeedReset;
         len_ff <= 32'd0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         hash_ff <= hash_in;
         len_ff <= len_in;
      end
      fin_ff <= fin_in;
      rsp_hash_ff <= rsp_hash_in;
   end

endmodule

>>> rtl/murmur3_32_hash.sv
// Top level of the streaming 32-bit Murmur3 hash block.
//
// Keys arrive on the req_ channel as little-endian words, up to four bytes per
// transaction, with a byte count and a last flag. A word with fewer than four
// bytes, or any word with the last flag set, ends the key, and one transaction
// with the final hash then leaves on the rsp_ channel. The csr_ channel loads
// the seed, which is used from the start of the next key; it resets to 42.
// A three-stage front end masks and scrambles each word (two registered
// multiplies), and a four-entry queue hands the words to the back end.
// The back end mixes one full word per cycle while it is not finalizing, so key
// words stream at one transaction per cycle until the finalizer or a stalled
// receiver fills the queue. A word that ends a key holds the back end through
// StFin1 and StFin2 (registered finalizer multiplies) and StFin3 (result load).
// Reset empties the pipeline and the queue and starts a fresh key.
// When the receiver stalls, the result register holds its transaction, the
// back end waits at the next result, and the queue and front end fill before
// req_ready falls.
module murmur3_32_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_key_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_hash_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_seed
);

   logic [31:0]       seed_reg_ff, seed_reg_in;
   logic              push_valid, push_ready;
   mm3_pkg::item_type push_item;
   logic              pop_valid, pop_ready;
   mm3_pkg::item_type pop_item;

   assign csr_ready = 1'b1;
   assign seed_reg_in = (csr_valid && csr_ready) ? csr_seed : seed_reg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_reg_ff <= mm3_pkg::SeedReset;
      end else begin
         seed_reg_ff <= seed_reg_in;
      end
   end

   mm3_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_key_word   (req_key_word),
      .req_byte_count (req_byte_count),
      .req_last_word  (req_last_word),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_item      (push_item)
   );

   mm3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   mm3_back u_back (
      .clock          (clock),
      .reset          (reset),
      .seed           (seed_reg_ff),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_item       (pop_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

>>> tb/murmur3_32_hash_test.sv
// Self-checking testbench for the streaming Murmur3 hash block with a scoreboard class.
module murmur3_32_hash_test;

   class hash_scoreboard;
      logic [31:0] seed_value;
      logic [31:0] running_hash;
      logic [31:0] key_length;
      bit          key_start;
      logic [31:0] pending_hashes[$];
      int unsigned words_seen;
      int unsigned hashes_checked;
      int unsigned error_count;

      function new();
         seed_value = mm3_pkg::SeedReset;
         running_hash = mm3_pkg::SeedReset;
         key_length = 32'd0;
         key_start = 1'b1;
         words_seen = 0;
         hashes_checked = 0;
         error_count = 0;
      endfunction

      function logic [31:0] rotate_left(logic [31:0] x, int unsigned r);
         logic [63:0] doubled;
         doubled = {x, x} << r;
         return doubled[63:32];
      endfunction

      function logic [31:0] scramble_key(logic [31:0] k);
         logic [31:0] t;
         t = k * mm3_pkg::C1;
         t = rotate_left(t, mm3_pkg::R1);
         return t * mm3_pkg::C2;
      endfunction

      function logic [31:0] finalize(logic [31:0] h);
         logic [31:0] t;
         t = h ^ (h >> 16);
         t = t * mm3_pkg::F1;
         t = t ^ (t >> 13);
         t = t * mm3_pkg::F2;
         return t ^ (t >> 16);
      endfunction

      function void note_word(logic [31:0] word, logic [2:0] count, bit last);
         logic [2:0]  n;
         logic [31:0] h;
         logic [31:0] mask;
         n = (count > mm3_pkg::FullCount) ? mm3_pkg::FullCount : count;
         words_seen++;
         if (key_start) begin
            running_hash = seed_value;
            key_length = 32'd0;
            key_start = 1'b0;
         end
         h = running_hash;
         key_length = key_length + n;
         if (n == mm3_pkg::FullCount) begin
            h = h ^ scramble_key(word);
            h = rotate_left(h, mm3_pkg::R2);
            h = h * 32'd5 + mm3_pkg::MixAdd;
            if (!last) begin
               running_hash = h;
               return;
            end
         end else if (n != 3'd0) begin
            mask = (32'd1 << (8 * n)) - 32'd1;
            h = h ^ scramble_key(word & mask);
         end
         h = finalize(h ^ key_length);
         pending_hashes.push_back(h);
         running_hash = h;
         key_start = 1'b1;
      endfunction

      function void check_hash(logic [31:0] actual);
         logic [31:0] expected;
         if (pending_hashes.size() == 0) begin
            $error("hash_value: no transaction expected, actual %h", actual);
            error_count++;
            return;
         end
         expected = pending_hashes.pop_front();
         hashes_checked++;
         if (actual !== expected) begin
            $error("hash_value: expected %h, actual %h", expected, actual);
            error_count++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_key_word;
   logic [2:0]  req_byte_count;
   logic        req_last_word;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_hash_value;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_seed;

   hash_scoreboard sb;
   bit          no_idle;
   bit          hold_now;
   int unsigned items_sent;
   int unsigned seeds_written;

   murmur3_32_hash dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_key_word   (req_key_word),
      .req_byte_count (req_byte_count),
      .req_last_word  (req_last_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_seed       (csr_seed)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 800000);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [31:0] random_word();
      case ($urandom_range(15))
         0: return 32'h00000000;
         1: return 32'hffffffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(input logic [31:0] word, input logic [2:0] count, input bit last);
      while (!no_idle && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_key_word <= word;
      req_byte_count <= count;
      req_last_word <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_word(word, count, last);
      items_sent++;
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (sb.pending_hashes.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      wait_for_idle();
      csr_valid <= 1'b1;
      csr_seed <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.seed_value = value;
      seeds_written++;
   endtask

   task automatic send_random_key();
      int unsigned words;
      int unsigned i;
      words = $urandom_range(0, 6);
      if ($urandom_range(9) == 0) words = $urandom_range(7, 16);
      for (i = 0; i < words; i++) begin
         send_word(random_word(),
                   ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7))
                                             : mm3_pkg::FullCount,
                   1'b0);
      end
      if ($urandom_range(3) == 0) send_word(random_word(), mm3_pkg::FullCount, 1'b1);
      else send_word(random_word(), 3'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
   endtask

   task automatic run_phase(input int unsigned target);
      int unsigned start;
      start = items_sent;
      while (items_sent - start < target) begin
         if ($urandom_range(9) == 0) begin
            send_word(random_word(), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
         end else begin
            send_random_key();
         end
      end
      if (!sb.key_start) send_word(random_word(), 3'($urandom_range(0, 3)), 1'b1);
   endtask

   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_hash(rsp_hash_value);
         if (hold_now) begin
            hold_left = 300;
            hold_now = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (no_idle) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 12);
         end
      end
   end

   initial begin
      sb = new();
      no_idle = 1'b0;
      hold_now = 1'b0;
      items_sent = 0;
      seeds_written = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_key_word <= 32'd0;
      req_byte_count <= 3'd0;
      req_last_word <= 1'b0;
      csr_valid <= 1'b0;
      csr_seed <= 32'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(32'h00000000, 3'd0, 1'b1);
      send_word(32'hdeadbeff, 3'd1, 1'b1);
      send_word(32'h12345678, 3'd2, 1'b1);
      send_word(32'hffffffff, 3'd3, 1'b1);
      send_word(32'hffffffff, mm3_pkg::FullCount, 1'b1);
      send_word(32'h00000000, mm3_pkg::FullCount, 1'b1);
      send_word(32'h89abcdef, 3'd5, 1'b1);
      send_word(32'h01020304, 3'd6, 1'b0);
      send_word(32'hfedcba98, 3'd7, 1'b0);
      send_word(32'hcafef00d, 3'd2, 1'b0);
      send_word(32'h11111111, mm3_pkg::FullCount, 1'b0);
      send_word(32'h22222222, mm3_pkg::FullCount, 1'b0);
      send_word(32'h33333333, 3'd3, 1'b0);
      send_word(32'h44444444, mm3_pkg::FullCount, 1'b0);
      send_word(32'h55555555, 3'd0, 1'b0);
      send_word(32'h66666666, mm3_pkg::FullCount, 1'b0);
      // The seed written in the middle of a key takes effect with the following key.
      write_seed(32'hffffffff);
      send_word(32'h777777aa, 3'd1, 1'b1);
      send_word(32'h00000000, 3'd0, 1'b1);
      write_seed(32'h00000000);
      send_word(32'h00000000, 3'd0, 1'b1);
      send_word(32'h00000000, mm3_pkg::FullCount, 1'b1);

      write_seed($urandom);
      run_phase(220);
      write_seed(32'h00000000);
      hold_now = 1'b1;
      run_phase(220);
      write_seed(32'hffffffff);
      no_idle = 1'b1;
      run_phase(220);
      no_idle = 1'b0;
      write_seed($urandom);
      run_phase(220);
      write_seed(mm3_pkg::SeedReset);
      run_phase(220);

      req_valid <= 1'b0;
      while (sb.pending_hashes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Run covered %0d key words and %0d hash results under %0d seed writes.",
               sb.words_seen, sb.hashes_checked, seeds_written);
      $display("Stimulus mixed directed tails and counts with random keys, noise and stalls.");
      if (sb.error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/mm3_pkg.sv
rtl/mm3_front.sv
rtl/mm3_queue.sv
rtl/mm3_back.sv
rtl/murmur3_32_hash.sv
tb/murmur3_32_hash_test.sv
